// ----- sv/vlfd_pkg.sv -----
// ----------------------------------------------------------------------------
// vlfd_pkg
// shared types and constants of the varint length field deframer
// ----------------------------------------------------------------------------
package vlfd_pkg;

	localparam int LEN_BITS   = 32;
	localparam int MAX_HEADER = 8;
	localparam int QDEPTH     = 2;

	localparam int HSW = $clog2(MAX_HEADER + 1);
	localparam int HCW = (HSW > 4) ? HSW : 4;
	localparam int SHW = $clog2(LEN_BITS + 7);
	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [3:0] HEADER_COUNT_RESET = 4'd2;
	localparam logic [7:0] FIELD_LIMIT_RESET  = 8'd16;

	localparam logic [7:0] CFG_HEADER_COUNT = 8'd0;
	localparam logic [7:0] CFG_FIELD_LIMIT  = 8'd1;

	typedef enum logic [2:0] {
		KIND_HEADER   = 3'd0,
		KIND_LEN_CONT = 3'd1,
		KIND_LEN_LAST = 3'd2,
		KIND_PAYLOAD  = 3'd3,
		KIND_IGNORED  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNC_LEN = 3'd1,
		ST_OVERRUN   = 3'd2,
		ST_SHORT_HDR = 3'd3,
		ST_TOO_WIDE  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_FSTART  = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_IGNORE  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
		logic       cont;
		logic [6:0] chunk;
	} item_t;

endpackage

// ----- sv/vlfd_front.sv -----
// ----------------------------------------------------------------------------
// vlfd_front
// input side: takes bytes, splits off the continuation bit and length chunk
// ----------------------------------------------------------------------------
module vlfd_front
	import vlfd_pkg::*;
(
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  logic       queue_full,
	output logic       push,
	output item_t      push_item
);

	assign byte_stall = queue_full;
	assign push       = byte_valid && !queue_full;

	always_comb begin
		push_item.data  = data_byte;
		push_item.eom   = end_of_message;
		push_item.cont  = data_byte[7];
		push_item.chunk = data_byte[6:0];
	end

endmodule

// ----- sv/vlfd_queue.sv -----
// ----------------------------------------------------------------------------
// vlfd_queue
// short item queue between the front and the parser
// ----------------------------------------------------------------------------
module vlfd_queue
	import vlfd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output item_t head
);

	item_t            entry_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign full      = (count_q == QCW'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	function automatic logic [QPW-1:0] next_ptr(input logic [QPW-1:0] p);
		next_ptr = (p == QPW'(QDEPTH - 1)) ? '0 : p + QPW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// ----- sv/vlfd_back.sv -----
// ----------------------------------------------------------------------------
// vlfd_back
// parser: header, length and payload tracking, result register
// ----------------------------------------------------------------------------
module vlfd_back
	import vlfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        q_not_empty,
	input  item_t       q_head,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  byte_kind,
	output logic [7:0]  byte_value,
	output logic [2:0]  header_index,
	output logic [7:0]  field_number,
	output logic [31:0] field_length,
	output logic        field_last_byte,
	output logic        message_done,
	output logic [2:0]  message_status,
	output logic [7:0]  fields_found
);

	logic [3:0]          header_count_q;
	logic [7:0]          field_limit_q;

	phase_t              phase_q;
	logic [HSW-1:0]      header_seen_q;
	logic [LEN_BITS-1:0] acc_q;
	logic [SHW-1:0]      shift_q;
	logic [LEN_BITS-1:0] remain_q;
	logic [7:0]          fcount_q;
	logic                werr_q;

	logic                valid_q;
	kind_t               kind_q;
	logic [7:0]          value_q;
	logic [2:0]          hidx_q;
	logic [7:0]          fnum_q;
	logic [31:0]         flen_q;
	logic                last_q;
	logic                done_q;
	status_t             status_q;
	logic [7:0]          found_q;

	phase_t              ph;
	logic [HSW-1:0]      hs_n;
	logic [LEN_BITS-1:0] acc_n;
	logic [SHW-1:0]      shift_n;
	logic [LEN_BITS-1:0] remain_n;
	logic [7:0]          fcount_n;
	logic                werr_n;
	kind_t               kind_n;
	logic [2:0]          hidx_n;
	logic [7:0]          fnum_n;
	logic [LEN_BITS-1:0] flen_n;
	logic                last_n;
	status_t             status_n;
	logic [7:0]          found_n;
	logic [HCW-1:0]      hc_ext;
	logic [HCW-1:0]      hc_eff;
	logic [LEN_BITS+6:0] placed;
	logic                partial;
	logic [8:0]          found_sum;

	assign cfg_ready = 1'b1;
	assign pop       = q_not_empty && (!valid_q || !result_stall);

	always_comb begin
		hc_ext    = HCW'(header_count_q);
		hc_eff    = (hc_ext > HCW'(MAX_HEADER)) ? HCW'(MAX_HEADER) : hc_ext;
		ph        = phase_q;
		hs_n      = header_seen_q;
		acc_n     = acc_q;
		shift_n   = shift_q;
		remain_n  = remain_q;
		fcount_n  = fcount_q;
		werr_n    = werr_q;
		kind_n    = KIND_IGNORED;
		hidx_n    = '0;
		fnum_n    = '0;
		flen_n    = '0;
		last_n    = 1'b0;
		status_n  = ST_OK;
		found_n   = '0;
		placed    = '0;
		partial   = 1'b0;
		found_sum = '0;

		if (ph == PH_HEADER && HCW'(header_seen_q) >= hc_eff) begin
			ph = PH_FSTART;
		end
		if (ph == PH_FSTART) begin
			if (fcount_q >= field_limit_q) begin
				ph = PH_IGNORE;
			end else begin
				ph      = PH_LENGTH;
				acc_n   = '0;
				shift_n = '0;
			end
		end

		case (ph)
			PH_HEADER: begin
				kind_n = KIND_HEADER;
				hidx_n = 3'(header_seen_q);
				hs_n   = header_seen_q + HSW'(1);
			end
			PH_LENGTH: begin
				fnum_n = fcount_q;
				if (shift_n < SHW'(LEN_BITS)) begin
					placed  = (LEN_BITS + 7)'(q_head.chunk) << shift_n;
					if (placed[LEN_BITS+6:LEN_BITS] != '0) begin
						werr_n = 1'b1;
					end
					acc_n   = acc_n | placed[LEN_BITS-1:0];
					shift_n = shift_n + SHW'(7);
				end else if (q_head.chunk != '0) begin
					werr_n = 1'b1;
				end
				if (q_head.cont) begin
					kind_n = KIND_LEN_CONT;
				end else begin
					kind_n = KIND_LEN_LAST;
					flen_n = acc_n;
					if (acc_n == '0) begin
						last_n   = 1'b1;
						fcount_n = fcount_q + 8'd1;
						ph       = PH_FSTART;
					end else begin
						remain_n = acc_n;
						ph       = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				kind_n   = KIND_PAYLOAD;
				fnum_n   = fcount_q;
				remain_n = remain_q - LEN_BITS'(1);
				if (remain_n == '0) begin
					last_n   = 1'b1;
					fcount_n = fcount_q + 8'd1;
					ph       = PH_FSTART;
				end
			end
			default: begin
				kind_n = KIND_IGNORED;
			end
		endcase

		if (q_head.eom) begin
			partial = (ph == PH_LENGTH) || (ph == PH_PAYLOAD);
			if (ph == PH_HEADER && HCW'(hs_n) < hc_eff) begin
				status_n = ST_SHORT_HDR;
			end else if (werr_n) begin
				status_n = ST_TOO_WIDE;
			end else if (ph == PH_LENGTH) begin
				status_n = ST_TRUNC_LEN;
			end else if (ph == PH_PAYLOAD) begin
				status_n = ST_OVERRUN;
			end else begin
				status_n = ST_OK;
			end
			found_sum = {1'b0, fcount_n} + {8'd0, partial};
			found_n   = found_sum[8] ? 8'hff : found_sum[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= HEADER_COUNT_RESET;
			field_limit_q  <= FIELD_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER_COUNT: header_count_q <= cfg_data[3:0];
				CFG_FIELD_LIMIT:  field_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			header_seen_q <= '0;
			acc_q         <= '0;
			shift_q       <= '0;
			remain_q      <= '0;
			fcount_q      <= '0;
			werr_q        <= 1'b0;
			valid_q       <= 1'b0;
		end else begin
			if (pop) begin
				if (q_head.eom) begin
					phase_q       <= PH_HEADER;
					header_seen_q <= '0;
					acc_q         <= '0;
					shift_q       <= '0;
					remain_q      <= '0;
					fcount_q      <= '0;
					werr_q        <= 1'b0;
				end else begin
					phase_q       <= ph;
					header_seen_q <= hs_n;
					acc_q         <= acc_n;
					shift_q       <= shift_n;
					remain_q      <= remain_n;
					fcount_q      <= fcount_n;
					werr_q        <= werr_n;
				end
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= kind_n;
			value_q  <= q_head.data;
			hidx_q   <= hidx_n;
			fnum_q   <= fnum_n;
			flen_q   <= 32'(flen_n);
			last_q   <= last_n;
			done_q   <= q_head.eom;
			status_q <= status_n;
			found_q  <= found_n;
		end
	end

	assign result_valid    = valid_q;
	assign byte_kind       = kind_q;
	assign byte_value      = value_q;
	assign header_index    = hidx_q;
	assign field_number    = fnum_q;
	assign field_length    = flen_q;
	assign field_last_byte = last_q;
	assign message_done    = done_q;
	assign message_status  = status_q;
	assign fields_found    = found_q;

endmodule

// ----- sv/varint_length_field_deframer_core.sv -----
// ----------------------------------------------------------------------------
// varint_length_field_deframer_core
// deframer for header bytes and base-128 length prefixed fields
// ----------------------------------------------------------------------------
// each accepted byte is written into a queue entry, then into the result register when the parser pops it
// throughput: one byte per cycle while result_stall is low, set by the parser update
// the two-entry queue and the result register let either side stall alone
// reset: parse state cleared, header_count 2, field_limit 16, queue empty
// ----------------------------------------------------------------------------
module varint_length_field_deframer_core
	import vlfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  byte_kind,
	output logic [7:0]  byte_value,
	output logic [2:0]  header_index,
	output logic [7:0]  field_number,
	output logic [31:0] field_length,
	output logic        field_last_byte,
	output logic        message_done,
	output logic [2:0]  message_status,
	output logic [7:0]  fields_found
);

	logic  push;
	item_t push_item;
	logic  pop;
	logic  queue_full;
	logic  q_not_empty;
	item_t q_head;

	vlfd_front u_front (
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.queue_full     (queue_full),
		.push           (push),
		.push_item      (push_item)
	);

	vlfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	vlfd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.q_not_empty     (q_not_empty),
		.q_head          (q_head),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.byte_kind       (byte_kind),
		.byte_value      (byte_value),
		.header_index    (header_index),
		.field_number    (field_number),
		.field_length    (field_length),
		.field_last_byte (field_last_byte),
		.message_done    (message_done),
		.message_status  (message_status),
		.fields_found    (fields_found)
	);

endmodule

// ----- tb/sv/varint_length_field_deframer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_length_field_deframer_core_test
// self-checking bench for the base-128 length prefixed field deframer: a
// directed table of messages and register settings, then random messages
// (well-formed, cut short, noisy, over-wide lengths) under bursty input and
// patterned output stall, each result checked against the table or a bit-true parser
// ----------------------------------------------------------------------------
module varint_length_field_deframer_core_test;
	import vlfd_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_BYTES = 1750;
	localparam logic [63:0] LEN_MASK = (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [2:0]  hidx;
		logic [7:0]  fnum;
		logic [31:0] flen;
		logic        last;
		logic        done;
		status_t     status;
		logic [7:0]  found;
	} deframe_result_t;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t         op;
		logic [7:0]      index;
		logic [7:0]      data;
		logic            eom;
		bit              typed;
		deframe_result_t exp;
	} stim_row_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_EVERY3, STALL_BURST} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = '0;
	logic        end_of_message = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  byte_kind;
	logic [7:0]  byte_value;
	logic [2:0]  header_index;
	logic [7:0]  field_number;
	logic [31:0] field_length;
	logic        field_last_byte;
	logic        message_done;
	logic [2:0]  message_status;
	logic [7:0]  fields_found;

	varint_length_field_deframer_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.end_of_message  (end_of_message),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.byte_kind       (byte_kind),
		.byte_value      (byte_value),
		.header_index    (header_index),
		.field_number    (field_number),
		.field_length    (field_length),
		.field_last_byte (field_last_byte),
		.message_done    (message_done),
		.message_status  (message_status),
		.fields_found    (fields_found)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// parser copy: registers and per-message state
	logic [3:0]  hdr_count_q = HEADER_COUNT_RESET;
	logic [7:0]  field_limit_q = FIELD_LIMIT_RESET;
	phase_t      ph = PH_HEADER;
	int unsigned hdr_seen = 0;
	logic [63:0] len_acc = '0;
	int unsigned len_shift = 0;
	logic [63:0] pay_left = '0;
	int unsigned field_cnt = 0;
	bit          wide_err = 1'b0;

	deframe_result_t expected_results[$];
	stim_row_t       stim_rows[$];
	logic [7:0]      msg_bytes[$];

	bit              row_typed = 1'b0;
	deframe_result_t row_exp = '0;
	deframe_result_t pred_res;
	deframe_result_t want_res;
	deframe_result_t got_res;

	int fail_count = 0;
	int results_checked = 0;
	int bytes_in = 0;
	int parsed_bytes = 0;
	int cfg_writes = 0;
	int messages = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int status_tally[5] = '{default: 0};
	bit moved;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	function automatic void clear_frame();
		ph = PH_HEADER;
		hdr_seen = 0;
		len_acc = '0;
		len_shift = 0;
		pay_left = '0;
		field_cnt = 0;
		wide_err = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [7:0] idx, input logic [7:0] val);
		if (idx == CFG_HEADER_COUNT)
			hdr_count_q = val[3:0];
		else if (idx == CFG_FIELD_LIMIT)
			field_limit_q = val;
	endfunction

	function automatic deframe_result_t decode_byte(input logic [7:0] b, input logic eom);
		deframe_result_t r;
		int unsigned hc;
		int unsigned room;
		int unsigned cnt;
		logic [63:0] chunk;
		bit partial;
		hc = (hdr_count_q > MAX_HEADER) ? MAX_HEADER : hdr_count_q;
		r = '0;
		r.kind = KIND_IGNORED;
		r.value = b;
		r.done = eom;
		r.status = ST_OK;
		chunk = {57'd0, b[6:0]};
		if (ph == PH_HEADER && hdr_seen >= hc)
			ph = PH_FSTART;
		if (ph == PH_FSTART) begin
			if (field_cnt >= field_limit_q) begin
				ph = PH_IGNORE;
			end else begin
				ph = PH_LENGTH;
				len_acc = '0;
				len_shift = 0;
			end
		end
		case (ph)
			PH_HEADER: begin
				r.kind = KIND_HEADER;
				r.hidx = hdr_seen[2:0];
				hdr_seen++;
			end
			PH_LENGTH: begin
				r.fnum = field_cnt[7:0];
				if (len_shift < LEN_BITS) begin
					room = LEN_BITS - len_shift;
					if (room < 7 && (chunk >> room) != 0)
						wide_err = 1'b1;
					len_acc = (len_acc | (chunk << len_shift)) & LEN_MASK;
					len_shift += 7;
				end else if (chunk != 0) begin
					wide_err = 1'b1;
				end
				if (b[7]) begin
					r.kind = KIND_LEN_CONT;
				end else begin
					r.kind = KIND_LEN_LAST;
					r.flen = len_acc[31:0];
					if (len_acc == 0) begin
						r.last = 1'b1;
						field_cnt++;
						ph = PH_FSTART;
					end else begin
						pay_left = len_acc;
						ph = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.fnum = field_cnt[7:0];
				pay_left--;
				if (pay_left == 0) begin
					r.last = 1'b1;
					field_cnt++;
					ph = PH_FSTART;
				end
			end
			default: ;
		endcase
		if (eom) begin
			partial = (ph == PH_LENGTH || ph == PH_PAYLOAD);
			if (ph == PH_HEADER && hdr_seen < hc)
				r.status = ST_SHORT_HDR;
			else if (wide_err)
				r.status = ST_TOO_WIDE;
			else if (ph == PH_LENGTH)
				r.status = ST_TRUNC_LEN;
			else if (ph == PH_PAYLOAD)
				r.status = ST_OVERRUN;
			cnt = field_cnt + partial;
			r.found = (cnt > 255) ? 8'd255 : cnt[7:0];
			clear_frame();
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch on %s at result %0d: got %0h want %0h", what,
				results_checked, got, want);
	endtask

	task automatic check_result(input deframe_result_t got, input deframe_result_t want);
		if (got.kind !== want.kind) report_mismatch("byte_kind", got.kind, want.kind);
		if (got.value !== want.value) report_mismatch("byte_value", got.value, want.value);
		if (got.hidx !== want.hidx) report_mismatch("header_index", got.hidx, want.hidx);
		if (got.fnum !== want.fnum) report_mismatch("field_number", got.fnum, want.fnum);
		if (got.flen !== want.flen) report_mismatch("field_length", got.flen, want.flen);
		if (got.last !== want.last) report_mismatch("field_last_byte", got.last, want.last);
		if (got.done !== want.done) report_mismatch("message_done", got.done, want.done);
		if (got.status !== want.status)
			report_mismatch("message_status", got.status, want.status);
		if (got.found !== want.found) report_mismatch("fields_found", got.found, want.found);
	endtask

	// input, register and result handshakes, all sampled at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				cfg_writes++;
				moved = 1'b1;
			end
			if (byte_valid && !byte_stall) begin
				pred_res = decode_byte(data_byte, end_of_message);
				expected_results.push_back(row_typed ? row_exp : pred_res);
				bytes_in++;
				if (pred_res.kind != KIND_IGNORED)
					parsed_bytes++;
				moved = 1'b1;
			end
			if (result_valid && !result_stall) begin
				got_res.kind = kind_t'(byte_kind);
				got_res.value = byte_value;
				got_res.hidx = header_index;
				got_res.fnum = field_number;
				got_res.flen = field_length;
				got_res.last = field_last_byte;
				got_res.done = message_done;
				got_res.status = status_t'(message_status);
				got_res.found = fields_found;
				if (expected_results.size() == 0) begin
					report_mismatch("result with no item pending", 1, 0);
				end else begin
					want_res = expected_results.pop_front();
					check_result(got_res, want_res);
					if (want_res.done)
						status_tally[want_res.status]++;
				end
				results_checked++;
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// result stall pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 200);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:   result_stall <= 1'b0;
			STALL_COIN:   result_stall <= ($urandom_range(0, 1) == 1);
			STALL_EVERY3: result_stall <= (stall_left % 3 == 0);
			default:      result_stall <= ((stall_left % 64) < 24);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic eom, input bit typed,
			input deframe_result_t exp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		data_byte <= b;
		end_of_message <= eom;
		row_typed <= typed;
		row_exp <= exp;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_valid high so that writes can follow back to back
	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic shuffle_regs();
		int pick;
		logic [3:0] hc;
		logic [7:0] fl;
		drain_results();
		pick = $urandom_range(0, 9);
		hc = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd8 : (pick == 2) ? 4'd15 :
			(pick == 3) ? 4'($urandom) : 4'($urandom_range(0, 4));
		pick = $urandom_range(0, 9);
		fl = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd1 :
			8'($urandom_range(2, 6));
		if ($urandom_range(0, 3) == 0)
			write_reg(8'($urandom_range(2, 255)), 8'($urandom));
		if ($urandom_range(0, 1) == 0) begin
			write_reg(CFG_HEADER_COUNT, {4'($urandom), hc});
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_FIELD_LIMIT, fl);
		end else begin
			write_reg(CFG_FIELD_LIMIT, fl);
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_HEADER_COUNT, {4'($urandom), hc});
		end
		cfg_valid <= 1'b0;
	endtask

	// groups of zero picks the shortest encoding, sometimes padded with zero groups
	task automatic push_length(input logic [63:0] v, input int unsigned groups);
		int unsigned n;
		int unsigned g;
		logic [63:0] part;
		logic cont;
		n = groups;
		if (n == 0) begin
			n = 1;
			while (n < 9 && (v >> (7 * n)) != 0) n++;
			if ($urandom_range(0, 5) == 0)
				n += $urandom_range(1, 3);
		end
		for (g = 0; g < n; g++) begin
			part = v >> (7 * g);
			cont = (g + 1 < n);
			msg_bytes.push_back({cont, part[6:0]});
		end
	endtask

	task automatic build_message();
		int unsigned hc;
		int unsigned style;
		int unsigned nf;
		int unsigned plen;
		int unsigned groups;
		int unsigned keep;
		logic [63:0] len_val;
		msg_bytes.delete();
		hc = (hdr_count_q > MAX_HEADER) ? MAX_HEADER : hdr_count_q;
		style = $urandom_range(0, 99);
		if (style < 8) begin
			repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
		end else begin
			repeat (hc) msg_bytes.push_back(8'($urandom));
			nf = $urandom_range(0, 4);
			repeat (nf) begin
				if (style < 16) begin
					len_val = {$urandom, $urandom};
					groups = $urandom_range(5, 7);
					plen = $urandom_range(0, 6);
				end else if (style < 22) begin
					len_val = {32'd0, $urandom};
					groups = 0;
					plen = $urandom_range(0, 8);
				end else begin
					len_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) :
						$urandom_range(0, 6);
					groups = 0;
					plen = 32'(len_val);
				end
				push_length(len_val, groups);
				repeat (plen) msg_bytes.push_back(8'($urandom));
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom));
			if (style >= 88 && msg_bytes.size() > 1) begin
				keep = $urandom_range(1, msg_bytes.size() - 1);
				while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
			end
		end
		if (msg_bytes.size() == 0)
			msg_bytes.push_back(8'($urandom));
	endtask

	function automatic deframe_result_t res(input kind_t k, input logic [7:0] v,
			input logic [2:0] hidx, input logic [7:0] fnum, input logic [31:0] flen,
			input logic last, input logic done, input status_t st, input logic [7:0] found);
		deframe_result_t r;
		r.kind = k;
		r.value = v;
		r.hidx = hidx;
		r.fnum = fnum;
		r.flen = flen;
		r.last = last;
		r.done = done;
		r.status = st;
		r.found = found;
		return r;
	endfunction

	task automatic row_byte(input logic [7:0] b, input logic eom);
		stim_row_t row;
		row.op = ROW_BYTE;
		row.index = '0;
		row.data = b;
		row.eom = eom;
		row.typed = 1'b0;
		row.exp = '0;
		stim_rows.push_back(row);
	endtask

	task automatic row_check(input logic [7:0] b, input logic eom, input deframe_result_t exp);
		stim_row_t row;
		row.op = ROW_BYTE;
		row.index = '0;
		row.data = b;
		row.eom = eom;
		row.typed = 1'b1;
		row.exp = exp;
		stim_rows.push_back(row);
	endtask

	task automatic row_cfg(input logic [7:0] idx, input logic [7:0] val);
		stim_row_t row;
		row.op = ROW_CFG;
		row.index = idx;
		row.data = val;
		row.eom = 1'b0;
		row.typed = 1'b0;
		row.exp = '0;
		stim_rows.push_back(row);
	endtask

	initial begin
		int directed_bytes;
		// two header bytes after reset, a two byte field, then an empty field
		row_check(8'h01, 0, res(KIND_HEADER, 8'h01, 0, 0, 0, 0, 0, ST_OK, 0));
		row_check(8'hFF, 0, res(KIND_HEADER, 8'hFF, 1, 0, 0, 0, 0, ST_OK, 0));
		row_check(8'h02, 0, res(KIND_LEN_LAST, 8'h02, 0, 0, 2, 0, 0, ST_OK, 0));
		row_byte(8'h00, 0);
		row_byte(8'hFF, 0);
		row_check(8'h00, 1, res(KIND_LEN_LAST, 8'h00, 0, 1, 0, 1, 1, ST_OK, 2));
		// short header
		row_check(8'hAA, 1, res(KIND_HEADER, 8'hAA, 0, 0, 0, 0, 1, ST_SHORT_HDR, 0));
		// truncated length
		row_byte(8'h10, 0);
		row_byte(8'h20, 0);
		row_check(8'hFF, 1, res(KIND_LEN_CONT, 8'hFF, 0, 0, 0, 0, 1, ST_TRUNC_LEN, 1));
		// payload overrun
		row_byte(8'h00, 0);
		row_byte(8'h00, 0);
		row_check(8'h05, 0, res(KIND_LEN_LAST, 8'h05, 0, 0, 5, 0, 0, ST_OK, 0));
		row_check(8'h7F, 1, res(KIND_PAYLOAD, 8'h7F, 0, 0, 0, 0, 1, ST_OVERRUN, 1));
		// no header, length wider than the accumulator
		row_cfg(CFG_HEADER_COUNT, 8'h00);
		repeat (4) row_byte(8'hFF, 0);
		row_check(8'h7F, 1, res(KIND_LEN_LAST, 8'h7F, 0, 0, 32'hFFFF_FFFF, 0, 1,
			ST_TOO_WIDE, 1));
		// field limit zero
		row_cfg(CFG_FIELD_LIMIT, 8'h00);
		row_check(8'h80, 1, res(KIND_IGNORED, 8'h80, 0, 0, 0, 0, 1, ST_OK, 0));
		// one header byte, one field allowed, then an ignored byte
		row_cfg(CFG_HEADER_COUNT, 8'hF1);
		row_cfg(CFG_FIELD_LIMIT, 8'h01);
		row_byte(8'h33, 0);
		row_byte(8'h00, 0);
		row_check(8'h44, 1, res(KIND_IGNORED, 8'h44, 0, 0, 0, 0, 1, ST_OK, 1));
		// saturated header count, widest field limit, index off the map
		row_cfg(CFG_HEADER_COUNT, 8'h0F);
		row_cfg(CFG_FIELD_LIMIT, 8'hFF);
		row_cfg(8'h02, 8'h5A);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].op == ROW_CFG) begin
				if (!cfg_valid)
					drain_results();
				write_reg(stim_rows[i].index, stim_rows[i].data);
				if (i == stim_rows.size() - 1 || stim_rows[i + 1].op != ROW_CFG)
					cfg_valid <= 1'b0;
			end else begin
				send_byte(stim_rows[i].data, stim_rows[i].eom, stim_rows[i].typed,
					stim_rows[i].exp);
			end
		end
		directed_bytes = bytes_in;

		while (bytes_in < directed_bytes + RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0)
				shuffle_regs();
			else if ($urandom_range(0, 39) == 0)
				drain_results();
			build_message();
			foreach (msg_bytes[i]) begin
				// registers may also change between two bytes of one message
				if ($urandom_range(0, 399) == 0)
					shuffle_regs();
				send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
			end
			messages++;
		end

		drain_results();
		if (expected_results.size() != 0)
			report_mismatch("items left without a result", expected_results.size(), 0);
		$display("covered %0d bytes (%0d parsed) in the directed table and %0d random messages",
			bytes_in, parsed_bytes, messages);
		$display("%0d register writes, end statuses ok %0d trunc %0d overrun %0d short %0d wide %0d",
			cfg_writes, status_tally[ST_OK], status_tally[ST_TRUNC_LEN],
			status_tally[ST_OVERRUN], status_tally[ST_SHORT_HDR], status_tally[ST_TOO_WIDE]);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
